>>> sv/assert_macros.svh
// assertion helpers used by binary_to_bcd_seven_segment
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> sv/bbss_pkg.sv
package bbss_pkg;

  localparam int VALUE_W  = 16;
  localparam int BCD_W    = 16;
  localparam int DIGIT_W  = 4;
  localparam int NUM_DIG  = 4;
  localparam int SEG_W    = 8;
  localparam int DCOUNT_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 3;

  // number of shift steps, one per cell
  localparam int NUM_CELLS = VALUE_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ORDER = 1'b1;

  localparam logic [DCOUNT_W-1:0] DCOUNT_RESET = 3'd4;
  localparam logic [DCOUNT_W-1:0] DCOUNT_TWO   = 3'd2;
  localparam logic [DCOUNT_W-1:0] DCOUNT_THREE = 3'd3;

  localparam logic [VALUE_W-1:0] LIMIT_TWO   = 16'd99;
  localparam logic [VALUE_W-1:0] LIMIT_THREE = 16'd999;
  localparam logic [VALUE_W-1:0] LIMIT_FOUR  = 16'd9999;

  localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ     = 4'd3;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

  // word handed from one cell to the next
  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
    logic               over;
  } dd_word_t;

  // value beyond what the selected digit count can show
  function automatic logic over_limit(input logic [VALUE_W-1:0] v,
                                      input logic [DCOUNT_W-1:0] dc);
    logic res;
    if (dc <= DCOUNT_TWO) begin
      res = (v > LIMIT_TWO);
    end else if (dc == DCOUNT_THREE) begin
      res = (v > LIMIT_THREE);
    end else begin
      res = (v > LIMIT_FOUR);
    end
    return res;
  endfunction

  // active-high glyph, bit 0 = segment a, point off
  function automatic logic [SEG_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] g;
    unique case (d)
      4'd0:    g = 8'h3F;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5B;
      4'd3:    g = 8'h4F;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6D;
      4'd6:    g = 8'h7D;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h6F;
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

endpackage

>>> sv/bbss_in_if.sv
interface bbss_in_if;
  import bbss_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> sv/bbss_out_if.sv
interface bbss_out_if;
  import bbss_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] seg_slot0;
  logic [SEG_W-1:0] seg_slot1;
  logic [SEG_W-1:0] seg_slot2;
  logic [SEG_W-1:0] seg_slot3;
  logic             out_of_range;

  modport source (output valid, output seg_slot0, output seg_slot1, output seg_slot2,
                  output seg_slot3, output out_of_range, input ready);
  modport sink   (input valid, input seg_slot0, input seg_slot1, input seg_slot2,
                  input seg_slot3, input out_of_range, output ready);
endinterface

>>> sv/binary_to_bcd_seven_segment.sv
// channel   dir  fields                                          width
// in_ch     in   value                                           16
// out_ch    out  seg_slot0..seg_slot3, out_of_range              8 x4, 1
// cfg       in   cfg_we, cfg_index, cfg_data (digit_count/order) 1, 1, 3
//
// one request accepted per cycle while the chain is not stalled; each result passes every cell, then the glyph register
// the path holds 16 double dabble cells (one shift each) plus the glyph register
// every stage has its own valid bit and ready, so bubbles close up under a stall
// synchronous active-low reset empties the chain; digit_count resets to 4, order to 0
`include "assert_macros.svh"

module binary_to_bcd_seven_segment (
  input  logic                            clk,
  input  logic                            rst_n,
  bbss_in_if.sink                         in_ch,
  bbss_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [bbss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bbss_pkg::*;

  logic [DCOUNT_W-1:0] digit_count_r;
  logic                reverse_order_r;

  logic     cell_valid [NUM_CELLS+1];
  logic     cell_ready [NUM_CELLS+1];
  dd_word_t cell_word  [NUM_CELLS+1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r   <= DCOUNT_RESET;
      reverse_order_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIGIT_COUNT:   digit_count_r   <= cfg_data[DCOUNT_W-1:0];
        CFG_REVERSE_ORDER: reverse_order_r <= cfg_data[0];
      endcase
    end
  end

  // entry word: empty digits, range check against the live limit
  assign cell_valid[0]     = in_ch.valid;
  assign in_ch.ready       = cell_ready[0];
  assign cell_word[0].bcd  = '0;
  assign cell_word[0].bin  = in_ch.value;
  assign cell_word[0].over = over_limit(in_ch.value, digit_count_r);

  // chain of shift cells
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    bbss_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cell_valid[i]),
      .up_ready (cell_ready[i]),
      .up_word  (cell_word[i]),
      .dn_valid (cell_valid[i+1]),
      .dn_ready (cell_ready[i+1]),
      .dn_word  (cell_word[i+1])
    );
  end

  // glyph mapping and result register
  bbss_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .digit_count   (digit_count_r),
    .reverse_order (reverse_order_r),
    .up_valid      (cell_valid[NUM_CELLS]),
    .up_ready      (cell_ready[NUM_CELLS]),
    .up_word       (cell_word[NUM_CELLS]),
    .dn_valid      (out_ch.valid),
    .dn_ready      (out_ch.ready),
    .seg_slot0     (out_ch.seg_slot0),
    .seg_slot1     (out_ch.seg_slot1),
    .seg_slot2     (out_ch.seg_slot2),
    .seg_slot3     (out_ch.seg_slot3),
    .out_of_range  (out_ch.out_of_range)
  );

  // an accepted request always lands in the first cell
  `ASSERT_NEXT(a_entry_taken, clk, rst_n, in_ch.valid && in_ch.ready, cell_valid[1])

  // out of range blanks every slot
  `ASSERT_IMPL(a_blank_over, clk, rst_n, out_ch.valid && out_ch.out_of_range, (out_ch.seg_slot0 == SEG_BLANK) && (out_ch.seg_slot1 == SEG_BLANK) && (out_ch.seg_slot2 == SEG_BLANK) && (out_ch.seg_slot3 == SEG_BLANK))

  // two-digit mode leaves the upper slots dark
  `ASSERT_IMPL(a_two_digit, clk, rst_n, out_ch.valid && (digit_count_r <= DCOUNT_TWO) && !reverse_order_r, (out_ch.seg_slot2 == SEG_BLANK) && (out_ch.seg_slot3 == SEG_BLANK))

endmodule

>>> sv/bbss_cell.sv
module bbss_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  bbss_pkg::dd_word_t up_word,
  output logic               dn_valid,
  input  logic               dn_ready,
  output bbss_pkg::dd_word_t dn_word
);
  import bbss_pkg::*;

  logic     valid_r;
  dd_word_t word_r;
  dd_word_t word_nxt;
  logic [BCD_W-1:0] adj;

  // add three to every digit of five or more
  always_comb begin
    for (int d = 0; d < NUM_DIG; d++) begin
      if (up_word.bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_ADJ_MIN) begin
        adj[d*DIGIT_W +: DIGIT_W] = up_word.bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_ADJ;
      end else begin
        adj[d*DIGIT_W +: DIGIT_W] = up_word.bcd[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // shift digits and binary left as one word
  always_comb begin
    word_nxt.bcd  = {adj[BCD_W-2:0], up_word.bin[VALUE_W-1]};
    word_nxt.bin  = {up_word.bin[VALUE_W-2:0], 1'b0};
    word_nxt.over = up_word.over;
  end

  assign up_ready = !valid_r || dn_ready;

  // stage occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_valid && up_ready) begin
      valid_r <= 1'b1;
    end else if (dn_ready) begin
      valid_r <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

>>> sv/bbss_out.sv
module bbss_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bbss_pkg::DCOUNT_W-1:0] digit_count,
  input  logic                          reverse_order,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  bbss_pkg::dd_word_t            up_word,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [bbss_pkg::SEG_W-1:0]    seg_slot0,
  output logic [bbss_pkg::SEG_W-1:0]    seg_slot1,
  output logic [bbss_pkg::SEG_W-1:0]    seg_slot2,
  output logic [bbss_pkg::SEG_W-1:0]    seg_slot3,
  output logic                          out_of_range
);
  import bbss_pkg::*;

  logic             valid_r;
  logic [SEG_W-1:0] slot [NUM_DIG];
  logic [SEG_W-1:0] seg0_r, seg1_r, seg2_r, seg3_r;
  logic [SEG_W-1:0] seg0_nxt, seg1_nxt, seg2_nxt, seg3_nxt;
  logic             over_r;
  logic [NUM_DIG-1:0] in_use;

  // digits shown in the selected mode
  always_comb begin
    in_use[0] = 1'b1;
    in_use[1] = 1'b1;
    in_use[2] = (digit_count > DCOUNT_TWO);
    in_use[3] = (digit_count > DCOUNT_THREE);
  end

  // glyph per digit, blank when unused or out of range
  always_comb begin
    for (int k = 0; k < NUM_DIG; k++) begin
      if (in_use[k] && !up_word.over) begin
        slot[k] = glyph(up_word.bcd[k*DIGIT_W +: DIGIT_W]);
      end else begin
        slot[k] = SEG_BLANK;
      end
    end
  end

  // optional swap of slot order
  always_comb begin
    if (reverse_order) begin
      seg0_nxt = slot[3];
      seg1_nxt = slot[2];
      seg2_nxt = slot[1];
      seg3_nxt = slot[0];
    end else begin
      seg0_nxt = slot[0];
      seg1_nxt = slot[1];
      seg2_nxt = slot[2];
      seg3_nxt = slot[3];
    end
  end

  assign up_ready = !valid_r || dn_ready;

  // result register occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_valid && up_ready) begin
      valid_r <= 1'b1;
    end else if (dn_ready) begin
      valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      seg0_r <= seg0_nxt;
      seg1_r <= seg1_nxt;
      seg2_r <= seg2_nxt;
      seg3_r <= seg3_nxt;
      over_r <= up_word.over;
    end
  end

  assign dn_valid     = valid_r;
  assign seg_slot0    = seg0_r;
  assign seg_slot1    = seg1_r;
  assign seg_slot2    = seg2_r;
  assign seg_slot3    = seg3_r;
  assign out_of_range = over_r;

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bbss_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_REQUESTS = 125;

  // glyphs for digits 0..9, digit 0 in the low byte
  localparam logic [9:0][SEG_W-1:0] DIGIT_GLYPH = {
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  typedef struct packed {
    logic [NUM_DIG-1:0][SEG_W-1:0] slot;
    logic                          over;
  } display_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  req_valid;
  logic [VALUE_W-1:0]    req_value;
  logic                  sink_ready = 1'b0;

  bbss_in_if  in_ch ();
  bbss_out_if out_ch ();

  assign in_ch.valid  = req_valid;
  assign in_ch.value  = req_value;
  assign out_ch.ready = sink_ready;

  binary_to_bcd_seven_segment u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  display_t          pending_displays[$];
  logic [DCOUNT_W-1:0] cur_dcount;
  logic              cur_reverse;
  int                mismatch_count = 0;
  int                cycle_count = 0;
  int                burst_left = 0;
  int                sink_mode = 0;
  int                sink_left = 0;
  int                stall_run = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected display for one value under the given settings
  function automatic display_t predict_display(input logic [VALUE_W-1:0] v,
                                               input logic [DCOUNT_W-1:0] dc,
                                               input logic rev);
    logic [BCD_W-1:0]              bcd;
    logic [VALUE_W-1:0]            bin;
    logic [VALUE_W-1:0]            lim;
    logic [NUM_DIG-1:0][SEG_W-1:0] slot;
    display_t                      res;
    int                            n;
    if (dc <= DCOUNT_TWO) begin
      n = 2;
      lim = LIMIT_TWO;
    end else if (dc == DCOUNT_THREE) begin
      n = 3;
      lim = LIMIT_THREE;
    end else begin
      n = 4;
      lim = LIMIT_FOUR;
    end
    res.over = (v > lim);
    slot = '0;
    if (!res.over) begin
      // shift-and-add-three over all sixteen bits
      bcd = '0;
      bin = v;
      for (int s = 0; s < VALUE_W; s++) begin
        for (int d = 0; d < NUM_DIG; d++) begin
          if (bcd[4*d +: 4] >= 4'd5) bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
        end
        bcd = {bcd[BCD_W-2:0], bin[VALUE_W-1]};
        bin = bin << 1;
      end
      for (int k = 0; k < n; k++) slot[k] = DIGIT_GLYPH[bcd[4*k +: 4]];
    end
    for (int k = 0; k < NUM_DIG; k++) res.slot[k] = rev ? slot[NUM_DIG-1-k] : slot[k];
    return res;
  endfunction

  // random value, weighted towards the range limit of the current mode
  function automatic logic [VALUE_W-1:0] pick_value(input logic [DCOUNT_W-1:0] dc);
    int lim;
    int pick;
    logic [VALUE_W-1:0] v;
    if (dc <= DCOUNT_TWO) lim = 99;
    else if (dc == DCOUNT_THREE) lim = 999;
    else lim = 9999;
    pick = $urandom_range(0, 9);
    if (pick <= 3) v = VALUE_W'($urandom_range(0, lim));
    else if (pick <= 5) v = VALUE_W'($urandom_range(lim - 3, lim + 3));
    else if (pick <= 7) v = VALUE_W'($urandom_range(0, 65535));
    else if (pick == 8) v = VALUE_W'($urandom_range(0, 9999));
    else v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
    return v;
  endfunction

  // one request, sent in bursts with random gaps between them
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 5);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
    end
    req_valid <= 1'b1;
    req_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    pending_displays.push_back(predict_display(v, cur_dcount, cur_reverse));
    burst_left--;
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
  endtask

  // write both display registers while the pipeline is empty
  task automatic set_display(input logic [DCOUNT_W-1:0] dc, input logic rev);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIGIT_COUNT;
    cfg_data  <= dc;
    @(posedge clk);
    cfg_index <= CFG_REVERSE_ORDER;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, rev};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_dcount  = dc;
    cur_reverse = rev;
  endtask

  // values under the reset settings: four digits, normal order
  task automatic test_reset_config();
    send_value(16'd0);
    send_value(16'd7);
    send_value(16'd1234);
    send_value(16'd5678);
    send_value(16'd9090);
    send_value(16'd9999);
    send_value(16'd10000);
    send_value(16'hFFFF);
  endtask

  // limits of each digit count, order swap and out-of-range counts
  task automatic test_digit_modes();
    set_display(3'd2, 1'b0);
    send_value(16'd99);
    send_value(16'd100);
    send_value(16'd256);
    // low byte is 99, so truncation would hide the overflow
    send_value(16'd355);
    set_display(3'd3, 1'b1);
    send_value(16'd999);
    send_value(16'd1000);
    send_value(16'd507);
    send_value(16'd42);
    // counts below two behave as two digits
    set_display(3'd0, 1'b0);
    send_value(16'd58);
    send_value(16'd100);
    set_display(3'd1, 1'b1);
    send_value(16'd12);
    // counts above four behave as four digits
    set_display(3'd7, 1'b1);
    send_value(16'd9999);
    send_value(16'd10000);
    send_value(16'd3);
  endtask

  // random values across a series of display settings
  task automatic test_random_traffic();
    logic [DCOUNT_W-1:0] dc;
    logic                rev;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      dc  = (p < 3) ? DCOUNT_W'(2 + p) : DCOUNT_W'($urandom_range(0, 7));
      rev = 1'($urandom_range(0, 1));
      set_display(dc, rev);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        // hold off once mid-phase until the pipeline has emptied
        if (p == 5 && i == PHASE_REQUESTS / 2) wait_drained();
        send_value(pick_value(dc));
      end
    end
  endtask

  // receiver back-pressure, switching between patterns
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_mode = $urandom_range(0, 3);
        sink_left = $urandom_range(20, 300);
      end
      sink_left--;
      case (sink_mode)
        0: begin
          sink_ready <= 1'b1;
        end
        1: begin
          sink_ready <= ($urandom_range(0, 2) != 0);
        end
        2: begin
          sink_ready <= (sink_left % 4 != 0);
        end
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            sink_ready <= 1'b0;
          end else begin
            sink_ready <= 1'b1;
            if ($urandom_range(0, 15) == 0) stall_run = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  // compare each result with the oldest expected display
  always @(posedge clk) begin : check_results
    display_t want;
    display_t got;
    if (rst_n && out_ch.valid && sink_ready) begin
      got.slot[0]  = out_ch.seg_slot0;
      got.slot[1]  = out_ch.seg_slot1;
      got.slot[2]  = out_ch.seg_slot2;
      got.slot[3]  = out_ch.seg_slot3;
      got.over     = out_ch.out_of_range;
      if (pending_displays.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, actual %h", $time, got);
      end else begin
        want = pending_displays.pop_front();
        for (int k = 0; k < NUM_DIG; k++) begin
          if (got.slot[k] !== want.slot[k]) begin
            mismatch_count++;
            $display("%0t: seg_slot%0d expected %h actual %h",
                     $time, k, want.slot[k], got.slot[k]);
          end
        end
        if (got.over !== want.over) begin
          mismatch_count++;
          $display("%0t: out_of_range expected %b actual %b", $time, want.over, got.over);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_n       = 1'b0;
    req_valid   = 1'b0;
    req_value   = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_DIGIT_COUNT;
    cfg_data    = '0;
    cur_dcount  = DCOUNT_RESET;
    cur_reverse = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_digit_modes();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/bbss_pkg.sv
sv/bbss_in_if.sv
sv/bbss_out_if.sv
sv/bbss_cell.sv
sv/bbss_out.sv
sv/binary_to_bcd_seven_segment.sv
test/testbench.sv
